FILE: hdl/planar_odometry_integrator_unit_assert.svh
// Assertion macros used by the checker file of the planar odometry integrator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_UNIT_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define POI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// Types, widths and constants shared by the planar odometry integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package poi_pkg;

    localparam int ANGLE_BITS_DEF  = 16;
    localparam int MAX_STEP_US_DEF = 1000000;

    localparam int VEL_W   = 16;
    localparam int POS_W   = 32;
    localparam int HEAD_W  = 16;
    localparam int STAMP_W = 32;

    // Wide enough for a 16-bit velocity times a time step of up to one second.
    localparam int PROD_W = 37;

    localparam int CORDIC_STEPS = 24;
    localparam int CORD_W       = 27;
    localparam int ZW           = 34;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 27'sd10188014;

    localparam int ACC_W = 64;

    // Dividend widths of the three serial divisions. Each dividend is biased by a
    // multiple of its divisor (plus half of it for heading and midpoint) so that it
    // is never negative; the bias drops out of the kept bits, or is subtracted for position.
    localparam int HDIV_W = 45;
    localparam int MDIV_W = 59;
    localparam int PDIV_W = 40;

    localparam int unsigned DIV_HEAD = 1000000;
    localparam int unsigned DIV_MID  = 2000000;
    localparam int unsigned DIV_POS  = 1000;

    localparam longint HEAD_BIAS = (64'sd1000000 <<< 24) + 64'sd500000;
    localparam longint MID_BIAS  = (64'sd2000000 <<< 36) + 64'sd1000000;
    localparam longint POS_RND   = 64'sd500 <<< 24;
    localparam longint POS_BIAS  = 64'sd1000 <<< 28;
    localparam longint POS_OFF   = 64'sd1 <<< 28;
    localparam int     POS_SCALE = 24;

    typedef struct packed {
        logic                     func;
        logic [STAMP_W-1:0]       stamp_us;
        logic signed [VEL_W-1:0]  vel_forward;
        logic signed [VEL_W-1:0]  vel_lateral;
        logic signed [VEL_W-1:0]  turn_rate;
        logic signed [POS_W-1:0]  new_x;
        logic signed [POS_W-1:0]  new_y;
        logic [HEAD_W-1:0]        new_heading;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pose_x;
        logic signed [POS_W-1:0]  pose_y;
        logic [HEAD_W-1:0]        pose_heading;
        logic                     is_reset_reply;
    } out_item_t;

    function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10680862;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PDIV_W+1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > $signed((PDIV_W+2)'(64'sd2147483647)))
            r = 32'sh7FFFFFFF;
        else if (v < $signed(-(PDIV_W+2)'(64'sd2147483648)))
            r = 32'sh80000000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/planar_odometry_integrator_unit.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit
// Dead-reckoning pose integrator with Euler and midpoint rules.
// ----------------------------------------------------------------------------
// One item is processed at a time. A velocity item passes through a bit-serial
// multiply over the time step bits, the heading and midpoint divisions side by
// side (the 59-bit midpoint dividend sets their length), 24 CORDIC iterations,
// a bit-serial rotation over the 27-bit sine and cosine, and the two position
// divisions. A pose reset item is finished in the idle state. The finished
// result sits in an output register, so a new item can be taken while that
// result still waits to be transferred.
`default_nettype none

module planar_odometry_integrator_unit #(
    parameter int ANGLE_BITS  = poi_pkg::ANGLE_BITS_DEF,
    parameter int MAX_STEP_US = poi_pkg::MAX_STEP_US_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire poi_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output poi_pkg::out_item_t     out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);

    localparam int DT_W   = $clog2(MAX_STEP_US + 1);
    localparam int P_W    = poi_pkg::VEL_W + DT_W + 1;
    localparam int SHIFT  = 32 - ANGLE_BITS;
    localparam int CW     = poi_pkg::CORD_W;
    localparam int ZW     = poi_pkg::ZW;
    localparam int AW     = poi_pkg::ACC_W;
    localparam int PW     = poi_pkg::PROD_W;
    localparam int HW     = poi_pkg::HDIV_W;
    localparam int MW     = poi_pkg::MDIV_W;
    localparam int QW     = poi_pkg::PDIV_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_HGO  = 3'd2;
    localparam logic [2:0] S_DIV1 = 3'd3;
    localparam logic [2:0] S_CORD = 3'd4;
    localparam logic [2:0] S_ROT  = 3'd5;
    localparam logic [2:0] S_PGO  = 3'd6;
    localparam logic [2:0] S_DIV2 = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       fin_reg, fin_next;
    logic       mode_reg, mode_next;

    logic signed [31:0]           pos_x_reg, pos_x_next;
    logic signed [31:0]           pos_y_reg, pos_y_next;
    logic [ANGLE_BITS-1:0]        head_reg, head_next;
    logic signed [15:0]           hv_f_reg, hv_f_next;
    logic signed [15:0]           hv_l_reg, hv_l_next;
    logic signed [15:0]           hv_t_reg, hv_t_next;
    logic [31:0]                  last_stamp_reg, last_stamp_next;
    logic                         seen_reg, seen_next;

    logic signed [15:0]           op_f_reg, op_f_next;
    logic signed [15:0]           op_l_reg, op_l_next;
    logic signed [15:0]           op_t_reg, op_t_next;
    logic [DT_W-1:0]              dt_sh_reg, dt_sh_next;
    logic signed [P_W-1:0]        acc_f_reg, acc_f_next;
    logic signed [P_W-1:0]        acc_l_reg, acc_l_next;
    logic signed [P_W-1:0]        acc_t_reg, acc_t_next;

    logic signed [CW-1:0]         cx_reg, cx_next;
    logic signed [CW-1:0]         cy_reg, cy_next;
    logic signed [ZW-1:0]         cz_reg, cz_next;
    logic                         flip_reg, flip_next;
    logic [CW-1:0]                c_sh_reg, c_sh_next;
    logic [CW-1:0]                s_sh_reg, s_sh_next;
    logic signed [AW-1:0]         px_reg, px_next;
    logic signed [AW-1:0]         py_reg, py_next;

    poi_pkg::out_item_t           res_reg, res_next;
    logic                         out_valid_reg, out_valid_next;
    poi_pkg::out_item_t           out_data_reg, out_data_next;

    logic                         accept;
    logic [31:0]                  diff;
    logic [DT_W-1:0]              dt;
    logic signed [PW-1:0]         turn_w;
    logic signed [MW-1:0]         turn_m;
    logic [HW-1:0]                h_dvd;
    logic [MW-1:0]                m_dvd;
    logic                         h_busy, m_busy, x_busy, y_busy;
    logic [HW-1:0]                h_quot;
    logic [MW-1:0]                m_quot;
    logic [QW-1:0]                x_quot, y_quot, x_dvd, y_dvd;
    logic signed [AW-1:0]         qx, qy;
    logic [31:0]                  ang, ang_f, half;
    logic                         flip;
    logic signed [CW-1:0]         dx, dy, xn, yn;
    logic signed [ZW-1:0]         at, zn;
    logic signed [AW-1:0]         df64, dl64, add_x, add_y;
    logic signed [QW:0]           ex, ey;
    logic signed [QW+1:0]         sum_x, sum_y;
    logic [31:0]                  head32, new_head32;
    logic                         start1, start2;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE || fin_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign start1 = state_reg == S_HGO;
    assign start2 = state_reg == S_PGO;

    // Time step, capped, and zero before the first stamp.
    assign diff = in_data.stamp_us - last_stamp_reg;
    assign dt   = !seen_reg ? '0 :
                  (diff > 32'(MAX_STEP_US)) ? DT_W'(MAX_STEP_US) : diff[DT_W-1:0];

    assign turn_w = PW'(acc_t_reg);
    assign turn_m = MW'(turn_w) <<< SHIFT;
    assign h_dvd  = HW'(turn_w) + HW'(poi_pkg::HEAD_BIAS);
    assign m_dvd  = turn_m + MW'(poi_pkg::MID_BIAS);

    // Rounding offset and the floor by 2^24 come first; the divide by 1000 follows.
    assign qx    = (px_reg + AW'(poi_pkg::POS_RND)) >>> poi_pkg::POS_SCALE;
    assign qy    = (py_reg + AW'(poi_pkg::POS_RND)) >>> poi_pkg::POS_SCALE;
    assign x_dvd = QW'(qx) + QW'(poi_pkg::POS_BIAS);
    assign y_dvd = QW'(qy) + QW'(poi_pkg::POS_BIAS);

    poi_sdiv #(.N(HW), .DIVISOR(poi_pkg::DIV_HEAD)) u_div_head (
        .clk(clk), .rst_n(rst_n), .start(start1), .dividend(h_dvd),
        .busy(h_busy), .quotient(h_quot)
    );

    poi_sdiv #(.N(MW), .DIVISOR(poi_pkg::DIV_MID)) u_div_mid (
        .clk(clk), .rst_n(rst_n), .start(start1), .dividend(m_dvd),
        .busy(m_busy), .quotient(m_quot)
    );

    poi_sdiv #(.N(QW), .DIVISOR(poi_pkg::DIV_POS)) u_div_x (
        .clk(clk), .rst_n(rst_n), .start(start2), .dividend(x_dvd),
        .busy(x_busy), .quotient(x_quot)
    );

    poi_sdiv #(.N(QW), .DIVISOR(poi_pkg::DIV_POS)) u_div_y (
        .clk(clk), .rst_n(rst_n), .start(start2), .dividend(y_dvd),
        .busy(y_busy), .quotient(y_quot)
    );

    // Sample angle on the 32-bit scale, with half the heading change added in midpoint mode.
    assign half  = mode_reg ? m_quot[31:0] : 32'd0;
    assign ang   = {head_reg, {SHIFT{1'b0}}} + half;
    assign ang_f = ang + 32'h4000_0000;
    assign flip  = ang_f[31];

    assign dx = cy_reg >>> cnt_reg;
    assign dy = cx_reg >>> cnt_reg;
    assign at = poi_pkg::atan_val(cnt_reg);
    assign xn = cz_reg[ZW-1] ? cx_reg + dx : cx_reg - dx;
    assign yn = cz_reg[ZW-1] ? cy_reg - dy : cy_reg + dy;
    assign zn = cz_reg[ZW-1] ? cz_reg + at : cz_reg - at;

    assign df64 = AW'(acc_f_reg);
    assign dl64 = AW'(acc_l_reg);

    // The top bit of each two's complement multiplier carries negative weight.
    always_comb
    begin
        add_x = (c_sh_reg[CW-1] ? df64 : '0) - (s_sh_reg[CW-1] ? dl64 : '0);
        add_y = (s_sh_reg[CW-1] ? df64 : '0) + (c_sh_reg[CW-1] ? dl64 : '0);
        if (cnt_reg == '0)
        begin
            add_x = -add_x;
            add_y = -add_y;
        end
    end

    assign ex    = $signed({1'b0, x_quot}) - $signed((QW+1)'(poi_pkg::POS_OFF));
    assign ey    = $signed({1'b0, y_quot}) - $signed((QW+1)'(poi_pkg::POS_OFF));
    assign sum_x = (QW+2)'(pos_x_reg) + (QW+2)'(ex);
    assign sum_y = (QW+2)'(pos_y_reg) + (QW+2)'(ey);

    assign head32     = 32'(head_reg);
    assign new_head32 = 32'(in_data.new_heading);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        fin_next        = fin_reg;
        mode_next       = mode_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        head_next       = head_reg;
        hv_f_next       = hv_f_reg;
        hv_l_next       = hv_l_reg;
        hv_t_next       = hv_t_reg;
        last_stamp_next = last_stamp_reg;
        seen_next       = seen_reg;
        op_f_next       = op_f_reg;
        op_l_next       = op_l_reg;
        op_t_next       = op_t_reg;
        dt_sh_next      = dt_sh_reg;
        acc_f_next      = acc_f_reg;
        acc_l_next      = acc_l_reg;
        acc_t_next      = acc_t_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        flip_next       = flip_reg;
        c_sh_next       = c_sh_reg;
        s_sh_next       = s_sh_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;

        if (cfg_valid && cfg_ready)
            mode_next = cfg_data;

        // A finished result moves to the output register once it is free.
        if (fin_reg && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
            fin_next       = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.func)
                    begin
                        res_next.pose_x         = pos_x_reg;
                        res_next.pose_y         = pos_y_reg;
                        res_next.pose_heading   = head32[15:0];
                        res_next.is_reset_reply = 1'b1;
                        pos_x_next = in_data.new_x;
                        pos_y_next = in_data.new_y;
                        head_next  = new_head32[ANGLE_BITS-1:0];
                        fin_next   = 1'b1;
                    end
                    else
                    begin
                        op_f_next       = hv_f_reg;
                        op_l_next       = hv_l_reg;
                        op_t_next       = hv_t_reg;
                        dt_sh_next      = dt;
                        acc_f_next      = '0;
                        acc_l_next      = '0;
                        acc_t_next      = '0;
                        hv_f_next       = in_data.vel_forward;
                        hv_l_next       = in_data.vel_lateral;
                        hv_t_next       = in_data.turn_rate;
                        last_stamp_next = in_data.stamp_us;
                        seen_next       = 1'b1;
                        cnt_next        = '0;
                        state_next      = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                acc_f_next = (acc_f_reg <<< 1) + (dt_sh_reg[DT_W-1] ? P_W'(op_f_reg) : '0);
                acc_l_next = (acc_l_reg <<< 1) + (dt_sh_reg[DT_W-1] ? P_W'(op_l_reg) : '0);
                acc_t_next = (acc_t_reg <<< 1) + (dt_sh_reg[DT_W-1] ? P_W'(op_t_reg) : '0);
                dt_sh_next = dt_sh_reg << 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == 5'(DT_W - 1))
                    state_next = S_HGO;
            end
            S_HGO:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (!h_busy && !m_busy)
                begin
                    head_next  = head_reg + h_quot[ANGLE_BITS-1:0];
                    flip_next  = flip;
                    cx_next    = poi_pkg::CORDIC_GAIN;
                    cy_next    = '0;
                    cz_next    = ZW'($signed(flip ? ang + 32'h8000_0000 : ang));
                    cnt_next   = '0;
                    state_next = S_CORD;
                end
            end
            S_CORD:
            begin
                cx_next  = xn;
                cy_next  = yn;
                cz_next  = zn;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(poi_pkg::CORDIC_STEPS - 1))
                begin
                    c_sh_next  = flip_reg ? -xn : xn;
                    s_sh_next  = flip_reg ? -yn : yn;
                    px_next    = '0;
                    py_next    = '0;
                    cnt_next   = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                px_next   = (px_reg <<< 1) + add_x;
                py_next   = (py_reg <<< 1) + add_y;
                c_sh_next = c_sh_reg << 1;
                s_sh_next = s_sh_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 5'(CW - 1))
                    state_next = S_PGO;
            end
            S_PGO:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (!x_busy && !y_busy)
                begin
                    pos_x_next              = poi_pkg::sat_pos(sum_x);
                    pos_y_next              = poi_pkg::sat_pos(sum_y);
                    res_next.pose_x         = poi_pkg::sat_pos(sum_x);
                    res_next.pose_y         = poi_pkg::sat_pos(sum_y);
                    res_next.pose_heading   = head32[15:0];
                    res_next.is_reset_reply = 1'b0;
                    fin_next                = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            fin_reg        <= 1'b0;
            mode_reg       <= 1'b0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            head_reg       <= '0;
            hv_f_reg       <= '0;
            hv_l_reg       <= '0;
            hv_t_reg       <= '0;
            last_stamp_reg <= '0;
            seen_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            fin_reg        <= fin_next;
            mode_reg       <= mode_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            head_reg       <= head_next;
            hv_f_reg       <= hv_f_next;
            hv_l_reg       <= hv_l_next;
            hv_t_reg       <= hv_t_next;
            last_stamp_reg <= last_stamp_next;
            seen_reg       <= seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_f_reg     <= op_f_next;
        op_l_reg     <= op_l_next;
        op_t_reg     <= op_t_next;
        dt_sh_reg    <= dt_sh_next;
        acc_f_reg    <= acc_f_next;
        acc_l_reg    <= acc_l_next;
        acc_t_reg    <= acc_t_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        flip_reg     <= flip_next;
        c_sh_reg     <= c_sh_next;
        s_sh_reg     <= s_sh_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: hdl/poi_sdiv.sv
// ----------------------------------------------------------------------------
// poi_sdiv
// Restoring divider by a constant, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module poi_sdiv #(
    parameter int N = poi_pkg::PDIV_W,
    parameter int unsigned DIVISOR = poi_pkg::DIV_POS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [N-1:0] dividend,
    output logic              busy,
    output logic [N-1:0]      quotient
);

    localparam int D_W   = $clog2(DIVISOR + 1);
    localparam int CNT_W = $clog2(N + 1);
    localparam logic [D_W:0] DV = (D_W+1)'(DIVISOR);

    logic [N-1:0]     q_reg, q_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W:0]     trial;
    logic             ge;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb
    begin
        trial    = {rem_reg, q_reg[N-1]};
        ge       = trial >= DV;
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(N);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? D_W'(trial - DV) : trial[D_W-1:0];
            q_next   = {q_reg[N-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = q_reg;

endmodule

`default_nettype wire

FILE: hdl/poi_checker.sv
// ----------------------------------------------------------------------------
// poi_checker
// Port-level checks on the planar odometry integrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "planar_odometry_integrator_unit_assert.svh"

module poi_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire poi_pkg::out_item_t out_data
);

    // A result waiting on a stalled receiver stays put.
    `POI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // Work on one item blocks the input for at least the next cycle.
    `POI_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "input open right after a transfer")

    // A result only appears after the block has been busy with an item.
    `POI_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result appeared without work")

endmodule

bind planar_odometry_integrator_unit poi_checker u_poi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
